[rtl/quaternion_rotate_assert.svh]
// Assertion macros for the quaternion rotation block.
// Expects signals clk and arst_n in the including module's scope.
`ifndef QUATERNION_ROTATE_ASSERT_SVH
`define QUATERNION_ROTATE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define QROT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define QROT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/qrot_pkg.sv]
// Shared types, widths, codes and the round/saturate function for the
// quaternion rotation block. No dependencies.
package qrot_pkg;

	localparam int PT_W    = 24;            // point component width, Q8.16
	localparam int ROT_W   = 16;            // rotation component width, Q2.14
	localparam int FRAC    = 14;            // fraction bits of the rotation
	localparam int RB_W    = ROT_W + 1;     // room for the negated minimum
	localparam int PROD_W  = PT_W + RB_W;
	localparam int SUM_W   = PROD_W + 2;    // four-term sum
	localparam int RND_W   = SUM_W + 1;

	// component order inside vectors
	localparam int C_I  = 0;
	localparam int C_J  = 1;
	localparam int C_K  = 2;
	localparam int C_RE = 3;

	typedef logic signed [PT_W-1:0]   pt_t;
	typedef logic signed [ROT_W-1:0]  rot_t;
	typedef logic signed [RB_W-1:0]   rb_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [RND_W-1:0]  rnd_w_t;

	localparam rot_t ROT_ONE = rot_t'(1) <<< FRAC;

	typedef enum logic [1:0] {
		IDX_RE = 2'd0,
		IDX_I  = 2'd1,
		IDX_J  = 2'd2,
		IDX_K  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		pt_t pt_i;
		pt_t pt_j;
		pt_t pt_k;
		pt_t pt_re;
	} pt_beat_t;

	typedef struct packed {
		pt_t  out_i;
		pt_t  out_j;
		pt_t  out_k;
		pt_t  out_re;
		logic clipped;
	} res_beat_t;

	typedef struct packed {
		logic valid;
		logic clip;
	} ctl_t;

	typedef struct packed {
		pt_t  val;
		logic clip;
	} rnd_t;

	localparam rnd_w_t RND_HALF = {{(RND_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam rnd_w_t PT_MAX   = {{(RND_W-PT_W+1){1'b0}}, {(PT_W-1){1'b1}}};
	localparam rnd_w_t PT_MIN   = {{(RND_W-PT_W+1){1'b1}}, {(PT_W-1){1'b0}}};

	// round half up, drop the fraction, clamp to the point range
	function automatic rnd_t round_sat(input sum_t s);
		rnd_w_t biased;
		rnd_w_t sh;
		rnd_t   r;
		biased = rnd_w_t'(s) + RND_HALF;
		sh     = biased >>> FRAC;
		if (sh > PT_MAX) begin
			r.val  = PT_MAX[PT_W-1:0];
			r.clip = 1'b1;
		end else if (sh < PT_MIN) begin
			r.val  = PT_MIN[PT_W-1:0];
			r.clip = 1'b1;
		end else begin
			r.val  = sh[PT_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/qrot_if.sv]
// Valid/ready stream interfaces for point beats and result beats.
// Depends on qrot_pkg.
interface qrot_pt_if;
	import qrot_pkg::*;
	logic     valid;
	logic     ready;
	pt_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qrot_res_if;
	import qrot_pkg::*;
	logic      valid;
	logic      ready;
	res_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/qrot_ham.sv]
// Two-stage Hamilton product: sixteen partial products, then four-term sums.
// Depends on qrot_pkg. rot_first flips the cross terms to give b * a.
module qrot_ham (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          rot_first,
	input  qrot_pkg::ctl_t ctl_in,
	input  qrot_pkg::pt_t a [4],
	input  qrot_pkg::rb_t b [4],
	output qrot_pkg::ctl_t ctl_out,
	output qrot_pkg::sum_t sum [4]
);
	import qrot_pkg::*;

	prod_t prod_s1 [4][4];
	ctl_t  ctl_s1;
	sum_t  sum_s2 [4];
	ctl_t  ctl_s2;
	sum_t  sum_nxt [4];

	function automatic sum_t cross_term(input prod_t x, input prod_t y, input logic flip);
		return flip ? (sum_t'(y) - sum_t'(x)) : (sum_t'(x) - sum_t'(y));
	endfunction

	always_comb begin
		sum_nxt[C_RE] = sum_t'(prod_s1[C_RE][C_RE]) - sum_t'(prod_s1[C_I][C_I])
		              - sum_t'(prod_s1[C_J][C_J]) - sum_t'(prod_s1[C_K][C_K]);
		sum_nxt[C_I]  = sum_t'(prod_s1[C_I][C_RE]) + sum_t'(prod_s1[C_RE][C_I])
		              + cross_term(prod_s1[C_J][C_K], prod_s1[C_K][C_J], rot_first);
		sum_nxt[C_J]  = sum_t'(prod_s1[C_J][C_RE]) + sum_t'(prod_s1[C_RE][C_J])
		              + cross_term(prod_s1[C_K][C_I], prod_s1[C_I][C_K], rot_first);
		sum_nxt[C_K]  = sum_t'(prod_s1[C_K][C_RE]) + sum_t'(prod_s1[C_RE][C_K])
		              + cross_term(prod_s1[C_I][C_J], prod_s1[C_J][C_I], rot_first);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 4; m++) begin
				for (int n = 0; n < 4; n++) begin
					prod_s1[m][n] <= prod_t'(a[m]) * prod_t'(b[n]);
				end
			end
			for (int n = 0; n < 4; n++) begin
				sum_s2[n] <= sum_nxt[n];
			end
		end
	end

	assign ctl_out = ctl_s2;
	assign sum     = sum_s2;

endmodule

[rtl/quaternion_rotate.sv]
// Each point passes, in order, the product and sum registers of the first Hamilton
// product, the round/saturate register, those of the second, then the output register.
// Throughput: one point per cycle unless stalled; both Hamilton products are fully
// pipelined (products, sums, round/saturate), so a new point enters every cycle that the pipe advances.
// A two-entry output register absorbs back-pressure; input stalls when both are full.
// Reset clears all valid bits and loads the identity rotation (real part 1.0).
`include "quaternion_rotate_assert.svh"

// Top level of the quaternion rotation pipeline: r * q * conj(r).
// Depends on qrot_pkg, qrot_if and qrot_ham.
module quaternion_rotate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  qrot_pkg::cfg_idx_t          cfg_idx,
	input  logic [qrot_pkg::ROT_W-1:0]  cfg_wdata,
	qrot_pt_if.sink                     pt,
	qrot_res_if.source                  res
);
	import qrot_pkg::*;

	rot_t      rot_q [4];
	logic      adv;
	pt_t       q_vec [4];
	rb_t       rc_vec [4];
	rb_t       r_vec [4];
	ctl_t      ctl_in1;
	ctl_t      ctl_s2;
	sum_t      sum_s2 [4];
	rnd_t      rnd1 [4];
	pt_t       t_s3 [4];
	ctl_t      ctl_s3;
	ctl_t      ctl_s5;
	sum_t      sum_s5 [4];
	rnd_t      rnd2 [4];
	logic      push;
	logic      pop;
	res_beat_t push_data;
	res_beat_t head_q;
	res_beat_t skid_q;
	logic      head_v_q;
	logic      skid_v_q;

	// rotation registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[C_RE] <= ROT_ONE;
			rot_q[C_I]  <= '0;
			rot_q[C_J]  <= '0;
			rot_q[C_K]  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				IDX_RE:  rot_q[C_RE] <= $signed(cfg_wdata);
				IDX_I:   rot_q[C_I]  <= $signed(cfg_wdata);
				IDX_J:   rot_q[C_J]  <= $signed(cfg_wdata);
				IDX_K:   rot_q[C_K]  <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// advance the whole pipe unless the output buffer is full
	assign adv      = !(head_v_q && skid_v_q);
	assign pt.ready = adv;

	assign q_vec[C_I]  = pt.data.pt_i;
	assign q_vec[C_J]  = pt.data.pt_j;
	assign q_vec[C_K]  = pt.data.pt_k;
	assign q_vec[C_RE] = pt.data.pt_re;

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			r_vec[n] = rb_t'(rot_q[n]);
		end
		rc_vec[C_RE] = r_vec[C_RE];
		rc_vec[C_I]  = -r_vec[C_I];
		rc_vec[C_J]  = -r_vec[C_J];
		rc_vec[C_K]  = -r_vec[C_K];
	end

	assign ctl_in1 = '{valid: pt.valid, clip: 1'b0};

	// t = q * conj(r)
	qrot_ham u_ham_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.rot_first (1'b0),
		.ctl_in    (ctl_in1),
		.a         (q_vec),
		.b         (rc_vec),
		.ctl_out   (ctl_s2),
		.sum       (sum_s2)
	);

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			rnd1[n] = round_sat(sum_s2[n]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.clip  <= ctl_s2.clip | rnd1[C_I].clip | rnd1[C_J].clip
			              | rnd1[C_K].clip | rnd1[C_RE].clip;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 4; n++) begin
				t_s3[n] <= rnd1[n].val;
			end
		end
	end

	// f = r * t
	qrot_ham u_ham_f (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.rot_first (1'b1),
		.ctl_in    (ctl_s3),
		.a         (t_s3),
		.b         (r_vec),
		.ctl_out   (ctl_s5),
		.sum       (sum_s5)
	);

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			rnd2[n] = round_sat(sum_s5[n]);
		end
		push_data.out_i   = rnd2[C_I].val;
		push_data.out_j   = rnd2[C_J].val;
		push_data.out_k   = rnd2[C_K].val;
		push_data.out_re  = rnd2[C_RE].val;
		push_data.clipped = ctl_s5.clip | rnd2[C_I].clip | rnd2[C_J].clip
		                  | rnd2[C_K].clip | rnd2[C_RE].clip;
	end

	assign push = adv && ctl_s5.valid;
	assign pop  = head_v_q && res.ready;

	// output register plus skid entry; skid only fills while head is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !head_v_q) begin
			head_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !head_v_q) begin
			head_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign res.valid = head_v_q;
	assign res.data  = head_q;

	`QROT_ASSERT_NOW(a_skid_behind_head, skid_v_q, head_v_q, "skid entry valid without head")
	`QROT_ASSERT_NEXT(a_skid_moves_up, pop && skid_v_q, head_v_q && !skid_v_q,
		"skid beat lost when head drained")
	`QROT_ASSERT_NEXT(a_stall_holds_tail, !adv && ctl_s5.valid,
		ctl_s5.valid && $stable(ctl_s5.clip), "last stage changed during stall")
	`QROT_ASSERT_NEXT(a_held_beat_stays, head_v_q && !res.ready,
		head_v_q && $stable(head_q), "held result beat changed")

endmodule
